// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property whose consequence is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sefr_pkg.sv =====
package sefr_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 2;
	localparam int CNT_W  = 2;
	localparam int PH_W   = 3;
	localparam int IDX_W  = 1;

	// frame phase codes
	localparam logic [PH_W-1:0] PH_IDLE = 3'd0;
	localparam logic [PH_W-1:0] PH_CMD  = 3'd1;
	localparam logic [PH_W-1:0] PH_LEN  = 3'd2;
	localparam logic [PH_W-1:0] PH_BODY = 3'd3;
	localparam logic [PH_W-1:0] PH_END  = 3'd4;

	localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd2;

	// configuration register indexes and reset values
	localparam logic [IDX_W-1:0] REG_START_BYTE = 1'd0;
	localparam logic [IDX_W-1:0] REG_END_BYTE   = 1'd1;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h7F;
	localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h7E;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] end_byte;
	} sefr_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] command;
		logic [LEN_W-1:0]  payload_len;
		logic [BYTE_W-1:0] payload0;
		logic [BYTE_W-1:0] payload1;
	} sefr_result_t;

endpackage

// ===== design/sefr_parser.sv =====
module sefr_parser import sefr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_en,
	input  logic [BYTE_W-1:0] byte_in,
	input  sefr_cfg_t         cfg,
	output logic              res_valid,
	output sefr_result_t      res
);

	logic [PH_W-1:0]   phase_q, phase_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic [BYTE_W-1:0] cmd_q, cmd_n;
	logic [LEN_W-1:0]  len_q, len_n;
	logic [BYTE_W-1:0] xor_q, xor_n;
	logic [BYTE_W-1:0] pay_q [2];
	logic [BYTE_W-1:0] chk_q;
	logic              pay_we, chk_we;

	always_comb begin
		phase_n   = phase_q;
		count_n   = count_q;
		cmd_n     = cmd_q;
		len_n     = len_q;
		xor_n     = xor_q;
		pay_we    = 1'b0;
		chk_we    = 1'b0;
		res_valid = 1'b0;
		if (byte_en) begin
			// start byte wins over any other position
			if (byte_in == cfg.start_byte) begin
				phase_n = PH_CMD;
			end else begin
				case (phase_q)
					PH_CMD: begin
						cmd_n   = byte_in;
						xor_n   = byte_in;
						phase_n = PH_LEN;
					end
					PH_LEN: begin
						if (byte_in > MAX_PAYLOAD) begin
							phase_n = PH_IDLE;
						end else begin
							len_n   = byte_in[LEN_W-1:0];
							xor_n   = xor_q ^ byte_in;
							count_n = '0;
							phase_n = PH_BODY;
						end
					end
					PH_BODY: begin
						if (count_q < len_q) begin
							pay_we = 1'b1;
							xor_n  = xor_q ^ byte_in;
						end else if (count_q == len_q) begin
							chk_we = 1'b1;
						end
						// trailing word sits one past the check word
						if ({1'b0, count_q} >= ({1'b0, len_q} + 3'd1)) begin
							phase_n = PH_END;
						end
						count_n = count_q + 2'd1;
					end
					PH_END: begin
						phase_n = PH_IDLE;
						if (byte_in == cfg.end_byte && xor_q == chk_q) begin
							res_valid = 1'b1;
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
			xor_q   <= '0;
		end else begin
			phase_q <= phase_n;
			count_q <= count_n;
			cmd_q   <= cmd_n;
			len_q   <= len_n;
			xor_q   <= xor_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_q[count_q[0]] <= byte_in;
		end
		if (chk_we) begin
			chk_q <= byte_in;
		end
	end

	always_comb begin
		res.command     = cmd_q;
		res.payload_len = len_q;
		res.payload0    = (len_q != 2'd0) ? pay_q[0] : '0;
		res.payload1    = (len_q == 2'd2) ? pay_q[1] : '0;
	end

endmodule

// ===== design/sof_eof_xor_frame_receiver.sv =====
// a frame result is registered in the result register once its end word, held in the input register, passes the parser
// throughput: one word per cycle, no bubbles, while in_stall is low; the parser is a single stage
// between the input register and the result register
// the input register stalls only while a result is held by a stalled output
// reset (arst_n low, asynchronous): parser idle, no result pending,
// start_byte = 0x7f, end_byte = 0x7e
module sof_eof_xor_frame_receiver import sefr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              cfg_wr_en,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0] cfg_wdata,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] command,
	output logic [LEN_W-1:0]  payload_len,
	output logic [BYTE_W-1:0] payload0,
	output logic [BYTE_W-1:0] payload1
);

	sefr_cfg_t         cfg_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	sefr_result_t      out_q;
	logic              out_free;
	logic              proc_en;
	logic              res_valid;
	sefr_result_t      res;

	assign out_free = !out_valid_q || !out_stall;
	assign proc_en  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_BYTE_RST;
			cfg_q.end_byte   <= END_BYTE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_START_BYTE: cfg_q.start_byte <= cfg_wdata;
				REG_END_BYTE:   cfg_q.end_byte   <= cfg_wdata;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	sefr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (proc_en),
		.byte_in   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= proc_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && proc_en && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign command     = out_q.command;
	assign payload_len = out_q.payload_len;
	assign payload0    = out_q.payload0;
	assign payload1    = out_q.payload1;

endmodule

// ===== design/sefr_checker.sv =====
`include "assert_macros.svh"

module sefr_checker import sefr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [BYTE_W-1:0] command,
	input logic [LEN_W-1:0]  payload_len,
	input logic [BYTE_W-1:0] payload0,
	input logic [BYTE_W-1:0] payload1
);

	sefr_result_t res_bits;

	assign res_bits = {command, payload_len, payload0, payload1};

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(res_bits), "stalled result changed")
	`ASSERT_CLK(a_len_range, !out_valid || (payload_len != 2'd3), "payload length out of range")
	`ASSERT_CLK(a_pay1_zero, !out_valid || payload_len == 2'd2 || payload1 == '0, "payload1 not zero")
	`ASSERT_CLK(a_pay0_zero, !out_valid || payload_len != 2'd0 || payload0 == '0, "payload0 not zero")

endmodule

bind sof_eof_xor_frame_receiver sefr_checker u_sefr_checker (.*);

// ===== test/sof_eof_xor_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

module sof_eof_xor_frame_receiver_tb;
	import sefr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef enum {FR_GOOD, FR_BAD_CHECK, FR_BAD_END, FR_RESTART, FR_BAD_LEN} frame_fault_t;

	class frame_scoreboard;
		sefr_cfg_t         cfg;
		logic [PH_W-1:0]   phase;
		logic [CNT_W-1:0]  byte_count;
		logic [BYTE_W-1:0] held_command;
		logic [LEN_W-1:0]  held_length;
		logic [BYTE_W-1:0] held_payload[2];
		logic [BYTE_W-1:0] held_check;
		logic [BYTE_W-1:0] running_xor;
		sefr_result_t      expected_frames[$];
		int                errors;

		function new();
			cfg.start_byte = START_BYTE_RST;
			cfg.end_byte = END_BYTE_RST;
			phase = PH_IDLE;
			byte_count = '0;
			held_command = '0;
			held_length = '0;
			held_payload[0] = '0;
			held_payload[1] = '0;
			held_check = '0;
			running_xor = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
			case (idx)
				REG_START_BYTE: cfg.start_byte = val;
				REG_END_BYTE:   cfg.end_byte = val;
				default: ;
			endcase
		endfunction

		// one accepted rx word through the parser
		function void take_byte(logic [BYTE_W-1:0] b);
			sefr_result_t r;
			// start byte wins over every other position
			if (b == cfg.start_byte) begin
				phase = PH_CMD;
				return;
			end
			case (phase)
				PH_CMD: begin
					held_command = b;
					running_xor = b;
					phase = PH_LEN;
				end
				PH_LEN: begin
					if (b > MAX_PAYLOAD) begin
						phase = PH_IDLE;
					end else begin
						held_length = b[LEN_W-1:0];
						running_xor = running_xor ^ b;
						byte_count = '0;
						phase = PH_BODY;
					end
				end
				PH_BODY: begin
					if (byte_count < held_length) begin
						held_payload[byte_count[0]] = b;
						running_xor = running_xor ^ b;
					end else if (byte_count == held_length) begin
						held_check = b;
					end
					// trailing byte sits at held_length + 1
					if (int'(byte_count) >= int'(held_length) + 1)
						phase = PH_END;
					byte_count = byte_count + 1'b1;
				end
				PH_END: begin
					phase = PH_IDLE;
					if (b == cfg.end_byte && running_xor == held_check) begin
						r.command = held_command;
						r.payload_len = held_length;
						r.payload0 = (held_length >= 1) ? held_payload[0] : '0;
						r.payload1 = (held_length >= 2) ? held_payload[1] : '0;
						expected_frames.push_back(r);
					end
				end
				default: phase = PH_IDLE;
			endcase
		endfunction

		function void match_field(string name, logic [BYTE_W-1:0] e, logic [BYTE_W-1:0] a);
			if (a !== e) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_frame(sefr_result_t got);
			sefr_result_t e;
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected frame, expected none actual cmd %0h len %0h",
					$time, got.command, got.payload_len);
				errors++;
				return;
			end
			e = expected_frames.pop_front();
			match_field("command", e.command, got.command);
			match_field("payload_len", BYTE_W'(e.payload_len), BYTE_W'(got.payload_len));
			match_field("payload0", e.payload0, got.payload0);
			match_field("payload1", e.payload1, got.payload1);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte;
	logic              cfg_wr_en;
	logic [IDX_W-1:0]  cfg_index;
	logic [BYTE_W-1:0] cfg_wdata;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] command;
	logic [LEN_W-1:0]  payload_len;
	logic [BYTE_W-1:0] payload0;
	logic [BYTE_W-1:0] payload1;

	frame_scoreboard frames;
	bit              idle_on;
	int              hold_req;
	int              bytes_sent;

	sof_eof_xor_frame_receiver dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.command     (command),
		.payload_len (payload_len),
		.payload0    (payload0),
		.payload1    (payload1)
	);

	always #4 clk = ~clk;

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("sof_eof_xor_frame_receiver_tb: done, errors");
		$finish;
	end

	// result side: checks accepted results and plays the stall pattern
	initial begin : frame_sink
		int stall_left;
		sefr_result_t got;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.command = command;
				got.payload_len = payload_len;
				got.payload0 = payload0;
				got.payload1 = payload1;
				frames.check_frame(got);
			end
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 3);
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	task send_word(input logic [BYTE_W-1:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		frames.take_byte(b);
		bytes_sent++;
	endtask

	function automatic logic [BYTE_W-1:0] other_byte();
		logic [BYTE_W-1:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == frames.cfg.start_byte);
		return b;
	endfunction

	task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
			input logic [BYTE_W-1:0] p0, input logic [BYTE_W-1:0] p1,
			input frame_fault_t fault);
		logic [BYTE_W-1:0] words[$];
		logic [BYTE_W-1:0] chk;
		int pos;
		chk = cmd ^ len;
		words = '{frames.cfg.start_byte, cmd, len};
		if (fault == FR_BAD_LEN) begin
			words.push_back(other_byte());
			words.push_back(other_byte());
		end else begin
			if (len >= 1) begin
				words.push_back(p0);
				chk = chk ^ p0;
			end
			if (len >= 2) begin
				words.push_back(p1);
				chk = chk ^ p1;
			end
			if (fault == FR_BAD_CHECK)
				chk = chk ^ 8'($urandom_range(1, 255));
			words.push_back(chk);
			words.push_back(other_byte());
			if (fault == FR_BAD_END)
				words.push_back(frames.cfg.end_byte ^ 8'($urandom_range(1, 255)));
			else
				words.push_back(frames.cfg.end_byte);
		end
		if (fault == FR_RESTART) begin
			pos = $urandom_range(2, words.size() - 1);
			words.insert(pos, frames.cfg.start_byte);
		end
		foreach (words[i])
			send_word(words[i]);
	endtask

	task random_frame();
		int pick;
		logic [BYTE_W-1:0] len;
		frame_fault_t fault;
		pick = $urandom_range(0, 99);
		len = 8'($urandom_range(0, 2));
		if (pick < 8) begin
			repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
			return;
		end
		if (pick < 70)
			fault = FR_GOOD;
		else if (pick < 78)
			fault = FR_BAD_CHECK;
		else if (pick < 85)
			fault = FR_BAD_END;
		else if (pick < 93)
			fault = FR_RESTART;
		else begin
			fault = FR_BAD_LEN;
			len = 8'($urandom_range(3, 255));
		end
		send_frame(other_byte(), len, other_byte(), other_byte(), fault);
	endtask

	// stop offering and let every pending frame come out
	task drain_link();
		in_valid <= 1'b0;
		while (frames.expected_frames.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task set_framing(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] eb);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_START_BYTE;
		cfg_wdata <= sb;
		@(posedge clk);
		frames.set_reg(REG_START_BYTE, sb);
		cfg_index <= REG_END_BYTE;
		cfg_wdata <= eb;
		@(posedge clk);
		frames.set_reg(REG_END_BYTE, eb);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		logic [BYTE_W-1:0] sb;
		logic [BYTE_W-1:0] eb;
		int quota;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_on = 1'b1;
		hold_req = 0;
		bytes_sent = 0;
		frames = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle noise, length extremes, restart, drops
		send_word(8'h00);
		send_word(8'hFF);
		send_frame(8'hFF, 8'd2, 8'hFF, 8'h00, FR_GOOD);
		send_word(START_BYTE_RST);
		send_word(8'h01);
		send_frame(8'h00, 8'd0, 8'h00, 8'h00, FR_GOOD);
		send_frame(8'h01, 8'd3, 8'h00, 8'h00, FR_BAD_LEN);
		send_frame(8'h5A, 8'd1, 8'hA5, 8'h00, FR_BAD_CHECK);
		send_frame(8'h80, 8'd0, 8'h00, 8'h00, FR_BAD_END);

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				1: begin sb = 8'h00; eb = 8'hFF; end
				2: begin sb = 8'hFF; eb = 8'h00; end
				3: begin sb = 8'h33; eb = 8'h33; end
				4: begin sb = 8'h55; eb = 8'hAA; end
				8: begin sb = START_BYTE_RST; eb = END_BYTE_RST; end
				default: begin
					sb = 8'($urandom_range(0, 255));
					eb = 8'($urandom_range(0, 255));
				end
			endcase
			if (ph != 0) begin
				drain_link();
				set_framing(sb, eb);
			end
			if (ph == 8)
				idle_on = 1'b0;
			if (ph == 2) begin
				// long output hold while good frames keep coming, so input backs up
				idle_on = 1'b0;
				hold_req = 60;
				repeat (8) send_frame(other_byte(), 8'($urandom_range(0, 2)),
					other_byte(), other_byte(), FR_GOOD);
				idle_on = 1'b1;
			end
			quota = bytes_sent + ((ph == 3) ? 100 : 220);
			while (bytes_sent < quota)
				random_frame();
		end

		drain_link();
		repeat (8) @(posedge clk);
		if (frames.errors == 0)
			$display("sof_eof_xor_frame_receiver_tb: done, clean");
		else
			$display("sof_eof_xor_frame_receiver_tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/sefr_pkg.sv
design/sefr_parser.sv
design/sof_eof_xor_frame_receiver.sv
design/sefr_checker.sv
test/sof_eof_xor_frame_receiver_tb.sv
